// ===== src/mmgt_pkg.sv =====
package mmgt_pkg;

   // Fixed widths of the request and response fields.
   localparam int KEY_W   = 10;
   localparam int GAP_W   = 10;
   localparam int OUT_MAX = 1023;

   // Request operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_ERASE  = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_COUNT   = 7'b0000100,
      S_DESCEND = 7'b0001000,
      S_LEAF    = 7'b0010000,
      S_ASCEND  = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

endpackage

// ===== src/multiset_min_gap_tracker_top.sv =====
// Multiset minimum-gap tracker.
// A request transfer happens on a rising edge with start high and busy low. It carries
// req_operation (insert or erase one copy) and req_key. The block updates a per-key copy
// count and a segment tree over the key positions. It then gives one response transfer:
// rsp_valid is high for exactly one cycle with rsp_min_gap, rsp_gap_valid and
// rsp_erase_error. The receiver cannot stall, so the response is never held back.
// Busy is high in every cycle between the accepting edge and the return to idle
// that follows it. The response lies in the last of these cycles, and a new
// request may be taken at the edge that ends the cycle after it. The block takes no new
// request while it still works on the one before.
// The walk steps down one tree level per cycle with the descent's add/compare unit and
// then finds and writes the leaf. It then recombines one level per cycle on the way up,
// with the single read port of the node memory.
// A refused request (full count or erase of an absent key) goes from the count check to
// the response, one with a key out of range straight to it; both skip the tree walk.
// After reset a clearing pass writes every node memory and count memory entry, and busy
// stays high all the while.
module multiset_min_gap_tracker_top
   import mmgt_pkg::*;
#(
   parameter int KEY_SPACE  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_operation,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_valid,
   output logic [GAP_W-1:0] rsp_min_gap,
   output logic             rsp_gap_valid,
   output logic             rsp_erase_error
);

   // Widths derived from the key space.
   localparam int KB  = $clog2(KEY_SPACE);       // a key position
   localparam int VW  = $clog2(KEY_SPACE + 1);   // a key or the "none" code
   localparam int NW  = $clog2(4 * KEY_SPACE);   // a heap node index
   localparam int CAW = KB;                      // count memory address

   localparam logic [VW-1:0] NO_CODE = VW'(KEY_SPACE);

   typedef struct packed {
      logic [VW-1:0] lowest;
      logic [VW-1:0] highest;
      logic [VW-1:0] gap;
   } node_type;

   localparam node_type EMPTY_NODE = '{lowest: NO_CODE, highest: NO_CODE, gap: NO_CODE};

   // The memories. Both are written and read in clocked blocks with a registered read.
   node_type              node_mem [2**NW];
   logic [COUNT_BITS-1:0] count_mem [2**CAW];

   state_type state_ff, state_in;

   logic [NW-1:0]         clr_ff, clr_in;
   logic                  op_ff, op_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  err_ff, err_in;
   logic [KB-1:0]         lo_ff, lo_in;
   logic [KB-1:0]         hi_ff, hi_in;
   logic [NW-1:0]         node_ff, node_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   node_type              cur_ff, cur_in;
   logic [VW-1:0]         root_gap_ff, root_gap_in;

   // Memory ports.
   logic                  nwr_en;
   logic [NW-1:0]         nwr_addr;
   node_type              nwr_data;
   logic                  nrd_en;
   logic [NW-1:0]         nrd_addr;
   node_type              nrd_q;
   logic                  cwr_en;
   logic [CAW-1:0]        cwr_addr;
   logic [COUNT_BITS-1:0] cwr_data;
   logic                  crd_en;
   logic [COUNT_BITS-1:0] crd_q;

   // Datapath terms.
   logic                  accept;
   logic                  key_in_range;
   logic [KB-1:0]         key_idx;
   logic [KB:0]           mid_sum;
   logic [KB-1:0]         mid;
   logic [NW-1:0]         parent;
   node_type              left_c, right_c, merged, leaf_val;
   logic [VW-1:0]         span;

   assign accept       = start && !busy;
   assign key_in_range = (32'(req_key) < KEY_SPACE);
   assign key_idx      = KB'(key_ff);

   // The unit for the descent: one midpoint add and one compare per level.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[KB:1];

   // The leaf reflects the updated copy count of the key.
   always_comb begin
      leaf_val.lowest  = (cnt_ff != '0) ? VW'(key_idx) : NO_CODE;
      leaf_val.highest = leaf_val.lowest;
      leaf_val.gap     = (cnt_ff > COUNT_BITS'(1)) ? '0 : NO_CODE;
   end

   // Recombination of the current node with its sibling into their parent.
   assign parent  = node_ff >> 1;
   assign left_c  = node_ff[0] ? nrd_q  : cur_ff;
   assign right_c = node_ff[0] ? cur_ff : nrd_q;
   assign span    = right_c.lowest - left_c.highest;

   always_comb begin
      merged.gap = (right_c.gap < left_c.gap) ? right_c.gap : left_c.gap;
      if (left_c.highest != NO_CODE && right_c.lowest != NO_CODE && span < merged.gap) begin
         merged.gap = span;
      end
      merged.lowest  = (left_c.lowest != NO_CODE) ? left_c.lowest : right_c.lowest;
      merged.highest = (right_c.highest != NO_CODE) ? right_c.highest : left_c.highest;
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      err_in      = err_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      node_in     = node_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      root_gap_in = root_gap_ff;
      nwr_en      = 1'b0;
      nwr_addr    = node_ff;
      nwr_data    = leaf_val;
      nrd_en      = 1'b0;
      nrd_addr    = node_ff ^ NW'(1);
      cwr_en      = 1'b0;
      cwr_addr    = key_idx;
      cwr_data    = cnt_ff;
      crd_en      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            nwr_en   = 1'b1;
            nwr_addr = clr_ff;
            nwr_data = EMPTY_NODE;
            cwr_en   = 1'b1;
            cwr_addr = CAW'(clr_ff);
            cwr_data = '0;
            clr_in   = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_operation;
               key_in  = req_key;
               err_in  = 1'b0;
               lo_in   = '0;
               hi_in   = KB'(KEY_SPACE - 1);
               node_in = NW'(1);
               crd_en  = 1'b1;
               state_in = key_in_range ? S_COUNT : S_RESP;
            end
         end
         S_COUNT: begin
            priority if (op_ff == OP_INSERT && crd_q == '1) begin
               // The count is full: nothing changes.
               state_in = S_RESP;
            end else if (op_ff == OP_ERASE && crd_q == '0) begin
               err_in   = 1'b1;
               state_in = S_RESP;
            end else begin
               cnt_in   = (op_ff == OP_INSERT) ? crd_q + COUNT_BITS'(1)
                                               : crd_q - COUNT_BITS'(1);
               cwr_en   = 1'b1;
               cwr_data = cnt_in;
               state_in = S_DESCEND;
            end
         end
         S_DESCEND: begin
            if (lo_ff == hi_ff) begin
               state_in = S_LEAF;
            end else if (key_idx <= mid) begin
               hi_in   = mid;
               node_in = {node_ff[NW-2:0], 1'b0};
            end else begin
               lo_in   = mid + KB'(1);
               node_in = {node_ff[NW-2:0], 1'b1};
            end
         end
         S_LEAF: begin
            nwr_en   = 1'b1;
            nwr_addr = node_ff;
            nwr_data = leaf_val;
            cur_in   = leaf_val;
            nrd_en   = 1'b1;
            nrd_addr = node_ff ^ NW'(1);
            state_in = S_ASCEND;
         end
         S_ASCEND: begin
            nwr_en   = 1'b1;
            nwr_addr = parent;
            nwr_data = merged;
            cur_in   = merged;
            node_in  = parent;
            nrd_en   = 1'b1;
            nrd_addr = parent ^ NW'(1);
            if (parent == NW'(1)) begin
               root_gap_in = merged.gap;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         root_gap_ff <= NO_CODE;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         root_gap_ff <= root_gap_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      err_ff  <= err_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      node_ff <= node_in;
      cnt_ff  <= cnt_in;
      cur_ff  <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (nwr_en) begin
         node_mem[nwr_addr] <= nwr_data;
      end
      if (nrd_en) begin
         nrd_q <= node_mem[nrd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cwr_en) begin
         count_mem[cwr_addr] <= cwr_data;
      end
      if (crd_en) begin
         crd_q <= count_mem[CAW'(req_key)];
      end
   end

   // The gap fields of the response come straight from the root cache.
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_gap_valid   = (root_gap_ff != NO_CODE);
   assign rsp_erase_error = err_ff;
   assign rsp_min_gap     = !rsp_gap_valid ? '0
                          : (32'(root_gap_ff) > OUT_MAX) ? GAP_W'(OUT_MAX)
                          : GAP_W'(root_gap_ff);

`ifndef SYNTHESIS
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a request transfer");

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_err_is_erase : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_erase_error) |-> (op_ff == OP_ERASE))
      else $error("erase error flagged on an insert");

   a_ascend_node : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ASCEND) |-> (node_ff > NW'(1)))
      else $error("recombination reached past the root");

   a_descend_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESCEND) |-> (lo_ff <= hi_ff && key_idx >= lo_ff && key_idx <= hi_ff))
      else $error("descent lost the key range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the multiset minimum-gap tracker.
//
// Requests are driven as command transfers: start is raised at a falling edge with the
// operation and key, and is held until a rising edge finds busy low. The block then gives
// exactly one response transfer, marked by rsp_valid, which cannot be held off.
// Each accepted request goes to a small scoreboard. It keeps its own copy count per key.
// From those counts it works out the expected minimum gap, gap flag and erase error,
// and queues the outcome in order. Every response is popped and compared field by field.
module tb_top;
   import mmgt_pkg::*;

   // The key space and the copy count width match the block's defaults.
   localparam int KEY_SPACE      = 1024;
   localparam int COUNT_BITS     = 16;
   localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
   localparam int TARGET_ITEMS   = 900;
   localparam int CALM_ITEMS     = 120;   // final stretch of the run, driven with no gaps
   localparam int WATCHDOG_LIMIT = 20000; // outlasts the clearing pass after reset
   localparam int SETTLE_CYCLES  = 30;    // a little over one request's latency

   // One expected (or observed) response transfer.
   typedef struct {
      logic [GAP_W-1:0] min_gap;
      logic             gap_valid;
      logic             erase_error;
   } gap_report_type;

   // The scoreboard holds the predicted multiset and the queue of outstanding responses.
   class gap_scoreboard;
      int unsigned copies [KEY_SPACE];
      gap_report_type awaited [$];
      int unsigned errors;
      int unsigned requests;
      int unsigned responses;
      int unsigned inserts;
      int unsigned erases;
      int unsigned absent_erases;
      int unsigned full_inserts;
      int unsigned duplicate_reports;
      int unsigned widest_gap;

      // Scans the key space in order. A key held twice or more gives a gap of zero;
      // otherwise the gap is the smallest distance between neighbouring present keys.
      function gap_report_type smallest_gap(logic absent);
         gap_report_type r;
         int          last_key;
         int          best;
         last_key = -1;
         best     = KEY_SPACE;
         for (int k = 0; k < KEY_SPACE; k++) begin
            if (copies[k] != 0) begin
               if (copies[k] >= 2) best = 0;
               if (last_key >= 0 && k - last_key < best) best = k - last_key;
               last_key = k;
            end
         end
         r.gap_valid   = (best != KEY_SPACE);
         if (best > OUT_MAX) best = OUT_MAX;
         r.min_gap     = r.gap_valid ? GAP_W'(best) : '0;
         r.erase_error = absent;
         return r;
      endfunction

      function void note_request(logic op, logic [KEY_W-1:0] key);
         gap_report_type r;
         logic        absent;
         absent = 1'b0;
         requests++;
         if (op == OP_INSERT) begin
            inserts++;
            if (copies[key] < COUNT_MAX) copies[key]++;
            else full_inserts++;
         end else begin
            erases++;
            if (copies[key] == 0) begin
               absent = 1'b1;
               absent_erases++;
            end else begin
               copies[key]--;
            end
         end
         r = smallest_gap(absent);
         if (r.gap_valid && r.min_gap == 0) duplicate_reports++;
         if (r.gap_valid && r.min_gap > widest_gap) widest_gap = r.min_gap;
         awaited.push_back(r);
      endfunction

      function void check_response(logic [GAP_W-1:0] gap, logic valid, logic absent);
         gap_report_type want;
         if (awaited.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         responses++;
         if (gap !== want.min_gap) begin
            $error("min_gap: expected %0d, got %0d", want.min_gap, gap);
            errors++;
         end
         if (valid !== want.gap_valid) begin
            $error("gap_valid: expected %0d, got %0d", want.gap_valid, valid);
            errors++;
         end
         if (absent !== want.erase_error) begin
            $error("erase_error: expected %0d, got %0d", want.erase_error, absent);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_operation;
   logic [KEY_W-1:0] req_key;
   logic             rsp_valid;
   logic [GAP_W-1:0] rsp_min_gap;
   logic             rsp_gap_valid;
   logic             rsp_erase_error;

   gap_scoreboard    sb = new();
   int unsigned      stall_cycles = 0;
   bit               calm = 1'b0;   // set for the final stretch: no idling at all

   multiset_min_gap_tracker_top #(
      .KEY_SPACE  (KEY_SPACE),
      .COUNT_BITS (COUNT_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_min_gap     (rsp_min_gap),
      .rsp_gap_valid   (rsp_gap_valid),
      .rsp_erase_error (rsp_erase_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Responses are sampled at the rising edge that ends their cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_response(rsp_min_gap, rsp_gap_valid, rsp_erase_error);
      end
   end

   // The watchdog counts cycles in which neither a request nor a response transfer
   // happens. A healthy block never goes anywhere near the limit, even while clearing.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Holds start low for a burst of cycles, changing it at falling edges only.
   task automatic pause(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Offers one request and waits for the edge that accepts it. Afterwards the sender
   // may idle straight away, which lands the gap inside the block's walk, or first wait
   // for busy to fall, which lands it on the block's idle phase.
   task automatic send(logic op, logic [KEY_W-1:0] key);
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, key);
      if (!calm) begin
         case ($urandom_range(0, 5))
            0: pause($urandom_range(1, 3));
            1: begin
               pause(1);
               @(posedge clock);
               while (busy) @(posedge clock);
               pause($urandom_range(1, 3));
            end
            default: ;
         endcase
      end
   endtask

   // The sender stops until every outstanding response has been seen.
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Erases every held copy, leaving the multiset empty for the next episode.
   task automatic empty_multiset();
      for (int k = 0; k < KEY_SPACE; k++) begin
         while (sb.copies[k] != 0) send(OP_ERASE, KEY_W'(k));
      end
   endtask

   // One random episode. The key pool decides what the episode stresses: the full range
   // gives wide gaps and misses on erase, a tiny window gives duplicates, a medium
   // window gives small distinct gaps, and the edge pool mixes extreme keys.
   task automatic episode(int length);
      int               pool;
      int               lo;
      int               hi;
      logic [KEY_W-1:0] key;
      logic             op;
      pool = $urandom_range(0, 3);
      lo   = 0;
      hi   = KEY_SPACE - 1;
      if (pool == 1) begin
         lo = $urandom_range(0, KEY_SPACE - 8);
         hi = lo + $urandom_range(0, 7);
      end else if (pool == 2) begin
         lo = $urandom_range(0, KEY_SPACE - 64);
         hi = lo + 63;
      end
      repeat (length) begin
         if (pool == 3) begin
            case ($urandom_range(0, 4))
               0:       key = '0;
               1:       key = KEY_W'(1);
               2:       key = KEY_W'(KEY_SPACE - 2);
               3:       key = KEY_W'(KEY_SPACE - 1);
               default: key = KEY_W'($urandom_range(0, KEY_SPACE - 1));
            endcase
         end else begin
            key = KEY_W'($urandom_range(hi, lo));
         end
         op = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_ERASE;
         send(op, key);
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_INSERT;
      req_key       = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part. The first request waits out the clearing pass behind busy.
      send(OP_ERASE, '0);                        // erase on an empty multiset
      send(OP_INSERT, KEY_W'(KEY_SPACE - 1));    // a single key gives no gap
      send(OP_INSERT, '0);                       // widest possible gap
      send(OP_INSERT, KEY_W'(KEY_SPACE - 1));    // a duplicate forces a gap of zero
      send(OP_ERASE, KEY_W'(KEY_SPACE - 1));
      send(OP_ERASE, KEY_W'(KEY_SPACE - 1));     // back to a single key
      send(OP_ERASE, KEY_W'(KEY_SPACE - 1));     // erase of a key no longer held
      send(OP_INSERT, KEY_W'(512));
      send(OP_INSERT, KEY_W'(513));              // neighbours one apart
      send(OP_ERASE, '0);
      repeat (4) send(OP_INSERT, KEY_W'(700));   // several copies of one key
      send(OP_ERASE, KEY_W'(700));               // drops one copy, still a duplicate
      quiesce();

      // Random part: episodes of well-formed insert and erase traffic, often starting
      // from an empty multiset, with pauses until every response is back now and then.
      while (sb.requests < TARGET_ITEMS - CALM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) quiesce();
         if ($urandom_range(0, 1) == 0) empty_multiset();
         episode($urandom_range(15, 50));
      end

      // Final stretch at full rate.
      calm = 1'b1;
      while (sb.requests < TARGET_ITEMS) episode($urandom_range(15, 50));
      empty_multiset();

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d inserts (%0d at full count), %0d erases (%0d absent).",
               sb.requests, sb.inserts, sb.full_inserts, sb.erases, sb.absent_erases);
      $display("%0d responses checked, %0d with a duplicate gap, widest gap %0d.",
               sb.responses, sb.duplicate_reports, sb.widest_gap);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mmgt_pkg.sv
src/multiset_min_gap_tracker_top.sv
tb/sv/tb_top.sv
